@@ hdl/text_console_cursor_scroll_top_macros.svh @@
// ----------------------------------------------------------------------------
// text console assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH

// same-cycle implication
`define TCCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccs assertion failed");

// next-cycle implication
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccs assertion failed");

`endif

@@ hdl/tccs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// screen geometry, character codes and sequencer states of the text console
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int PR_W      = $clog2(ROWS);
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CELL_W    = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_WRITE,
        ST_CLEAR,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_MOVE,
        ST_DONE
    } t_state;

endpackage

@@ hdl/tccs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// simple dual-port screen memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/text_console_cursor_scroll_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// text-mode console: screen memory, cursor, wrap and scroll
// ----------------------------------------------------------------------------
// usage: one word in on the s_axis side, one word out on the m_axis side.
// tuser selects put (0) or cell read (1). a put writes or interprets a
// character at the cursor and reports the new cursor; a read returns a cell.
// colors come from the apb registers (fg at 0x0, bg at 0x4).
// the screen is a ring of rows over one memory: a scroll moves the top-row
// pointer and marks the new bottom row blank, so it costs no copy.
// each row has a valid bit; an invalid row reads as blank, and the first put
// into it blanks the row in memory first, one cell a cycle.
// a read from a blank-marked row returns a blank cell without a memory read;
// an off-screen one returns a zero cell. a put into a blank-marked row first
// sweeps the row on the single memory write port, then enters the write state
// again. after the result loads the sequencer returns to idle and takes the
// next word there. no clearing pass after reset: all rows start blank-marked.
// the input side is ready only while the sequencer is idle. the result sits
// in an output register; if the receiver stalls, the next word may be
// accepted but its result waits until the register is free.
// reset clears the cursor, top pointer, row marks and output valid, and sets fg 15, bg 0.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_top_macros.svh"

module text_console_cursor_scroll_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code[7:0], read_row[12:8], read_column[19:13]
    input  logic [0:0]  i_s_axis_tuser,   // operation[0]
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // cell_value[15:0], cursor_column[22:16],
                                          // cursor_row[27:23], scrolled[28]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W  = tccs_pkg::COL_W;
    localparam int ROW_W  = tccs_pkg::ROW_W;
    localparam int PR_W   = tccs_pkg::PR_W;
    localparam int ADDR_W = tccs_pkg::ADDR_W;
    localparam int CELL_W = tccs_pkg::CELL_W;

    tccs_pkg::t_state r_state, n_state;

    logic                r_op, n_op;
    logic [7:0]          r_char, n_char;
    logic [ROW_W-1:0]    r_rrow, n_rrow;
    logic [COL_W-1:0]    r_rcol, n_rcol;
    logic [PR_W-1:0]     r_prow, n_prow;
    logic [COL_W-1:0]    r_sweep, n_sweep;
    logic [PR_W-1:0]     r_top, n_top;
    logic [tccs_pkg::ROWS-1:0] r_row_valid, n_row_valid;
    logic [COL_W-1:0]    r_cur_col, n_cur_col;
    logic [ROW_W-1:0]    r_cur_row, n_cur_row;
    logic                r_scrolled, n_scrolled;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [3:0]          r_fg, r_bg;
    logic                r_out_valid;
    logic [31:0]         r_out_data;

    logic                w_load;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr, w_raddr, w_row_base;
    logic [CELL_W-1:0]   w_wdata, w_rdata;
    logic [ROW_W-1:0]    w_lrow;
    logic [PR_W:0]       w_sum;
    logic [PR_W-1:0]     w_prow_calc;
    logic                w_rd_ok;
    logic [COL_W:0]      w_col_nx;
    logic [ROW_W:0]      w_row_nx;
    logic                w_scroll;
    logic                w_cfg_wr;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == tccs_pkg::REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd15;
            r_bg <= 4'd0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == tccs_pkg::REG_FG) begin
                r_fg <= pwdata[3:0];
            end else begin
                r_bg <= pwdata[3:0];
            end
        end
    end

    // ---------------- screen memory ----------------
    tccs_ram #(
        .DEPTH (tccs_pkg::CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_row_base = ADDR_W'(ADDR_W'(r_prow) * ADDR_W'(tccs_pkg::COLUMNS));
    assign w_raddr    = w_row_base + ADDR_W'(r_rcol);

    // physical row of the logical row, modulo the ring
    assign w_lrow      = (r_op == tccs_pkg::OP_READ) ? r_rrow : r_cur_row;
    assign w_sum       = (PR_W+1)'(r_top) + (PR_W+1)'(w_lrow);
    assign w_prow_calc = (w_sum >= (PR_W+1)'(tccs_pkg::ROWS))
                       ? PR_W'(w_sum - (PR_W+1)'(tccs_pkg::ROWS)) : PR_W'(w_sum);
    assign w_rd_ok     = ({1'b0, r_rrow} < (ROW_W+1)'(tccs_pkg::ROWS))
                      && ({1'b0, r_rcol} < (COL_W+1)'(tccs_pkg::COLUMNS));

    // ---------------- cursor step ----------------
    always_comb begin
        w_col_nx = {1'b0, r_cur_col} + (COL_W+1)'(1);
        w_row_nx = {1'b0, r_cur_row};
        w_scroll = 1'b0;
        case (r_char)
            tccs_pkg::CH_NL: begin
                w_col_nx = '0;
                w_row_nx = {1'b0, r_cur_row} + (ROW_W+1)'(1);
            end
            tccs_pkg::CH_CR: begin
                w_col_nx = '0;
            end
            tccs_pkg::CH_TAB: begin
                w_col_nx = ({1'b0, r_cur_col} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
            end
            default: begin
                w_col_nx = {1'b0, r_cur_col} + (COL_W+1)'(1);
            end
        endcase
        if (w_col_nx >= (COL_W+1)'(tccs_pkg::COLUMNS)) begin
            w_col_nx = '0;
            w_row_nx = w_row_nx + (ROW_W+1)'(1);
        end
        if (w_row_nx >= (ROW_W+1)'(tccs_pkg::ROWS)) begin
            w_row_nx = (ROW_W+1)'(tccs_pkg::ROWS - 1);
            w_scroll = 1'b1;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccs_pkg::ST_IDLE;
            r_top       <= '0;
            r_row_valid <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_row_valid <= n_row_valid;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_char     <= n_char;
        r_rrow     <= n_rrow;
        r_rcol     <= n_rcol;
        r_prow     <= n_prow;
        r_sweep    <= n_sweep;
        r_scrolled <= n_scrolled;
        r_cell     <= n_cell;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_char      = r_char;
        n_rrow      = r_rrow;
        n_rcol      = r_rcol;
        n_prow      = r_prow;
        n_sweep     = r_sweep;
        n_top       = r_top;
        n_row_valid = r_row_valid;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_scrolled  = r_scrolled;
        n_cell      = r_cell;
        o_s_axis_tready = 1'b0;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_row_base + ADDR_W'(r_cur_col);
        w_wdata     = {r_bg, r_fg, r_char};

        case (r_state)
            tccs_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_op    = i_s_axis_tuser[0];
                    n_char  = i_s_axis_tdata[7:0];
                    n_rrow  = i_s_axis_tdata[12:8];
                    n_rcol  = i_s_axis_tdata[19:13];
                    n_state = tccs_pkg::ST_CALC;
                end
            end
            tccs_pkg::ST_CALC: begin
                n_prow     = w_prow_calc;
                n_cell     = '0;
                n_scrolled = 1'b0;
                if (r_op == tccs_pkg::OP_READ) begin
                    n_state = w_rd_ok ? tccs_pkg::ST_RD_ISSUE : tccs_pkg::ST_DONE;
                end else if (r_char == tccs_pkg::CH_NL || r_char == tccs_pkg::CH_CR
                          || r_char == tccs_pkg::CH_TAB) begin
                    n_state = tccs_pkg::ST_MOVE;
                end else begin
                    n_state = tccs_pkg::ST_WRITE;
                end
            end
            tccs_pkg::ST_WRITE: begin
                if (r_row_valid[r_prow]) begin
                    w_we    = 1'b1;
                    n_state = tccs_pkg::ST_MOVE;
                end else begin
                    n_sweep = '0;
                    n_state = tccs_pkg::ST_CLEAR;
                end
            end
            tccs_pkg::ST_CLEAR: begin
                // blank the row before its first real write
                w_we    = 1'b1;
                w_waddr = w_row_base + ADDR_W'(r_sweep);
                w_wdata = tccs_pkg::BLANK_CELL;
                n_sweep = r_sweep + COL_W'(1);
                if (r_sweep == COL_W'(tccs_pkg::COLUMNS - 1)) begin
                    n_row_valid[r_prow] = 1'b1;
                    n_state = tccs_pkg::ST_WRITE;
                end
            end
            tccs_pkg::ST_RD_ISSUE: begin
                if (r_row_valid[r_prow]) begin
                    n_state = tccs_pkg::ST_RD_WAIT;
                end else begin
                    n_cell  = tccs_pkg::BLANK_CELL;
                    n_state = tccs_pkg::ST_DONE;
                end
            end
            tccs_pkg::ST_RD_WAIT: begin
                n_cell  = w_rdata;
                n_state = tccs_pkg::ST_DONE;
            end
            tccs_pkg::ST_MOVE: begin
                n_cur_col  = COL_W'(w_col_nx);
                n_cur_row  = ROW_W'(w_row_nx);
                n_scrolled = w_scroll;
                if (w_scroll) begin
                    // old top row becomes the new bottom row, blank
                    n_row_valid[r_top] = 1'b0;
                    n_top = (r_top == PR_W'(tccs_pkg::ROWS - 1)) ? '0 : r_top + PR_W'(1);
                end
                n_state = tccs_pkg::ST_DONE;
            end
            tccs_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = tccs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tccs_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {3'd0, r_scrolled, r_cur_row, r_cur_col, r_cell};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    `TCCS_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_cur_col} < (COL_W+1)'(tccs_pkg::COLUMNS))
        && ({1'b0, r_cur_row} < (ROW_W+1)'(tccs_pkg::ROWS)))
    `TCCS_ASSERT_NOW(a_write_valid_row, i_clk, i_rst_n, w_we,
        (r_state == tccs_pkg::ST_CLEAR) || r_row_valid[r_prow])
    `TCCS_ASSERT_NEXT(a_scroll_moves_top, i_clk, i_rst_n,
        (r_state == tccs_pkg::ST_MOVE) && w_scroll, r_top != $past(r_top))
    `TCCS_ASSERT_NOW(a_scroll_last_row, i_clk, i_rst_n,
        r_out_valid && r_out_data[28],
        r_out_data[27:23] == ROW_W'(tccs_pkg::ROWS - 1))

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text console: puts, cell reads, wrap and scroll
// ----------------------------------------------------------------------------
// a queue of pending console items feeds a clocked stream driver; each word
// accepted on the input side runs through a screen and cursor shadow that
// predicts the output word. a clocked monitor pops predictions in order and
// compares every field. phases vary sender gaps, receiver stalls and the
// apb colors; one phase holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 166;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 200;

    typedef struct packed {
        logic       op;
        logic [6:0] rcol;
        logic [4:0] rrow;
        logic [7:0] ch;
    } t_console_item;

    // same layout as the output tdata, lowest field in the lowest bits
    typedef struct packed {
        logic       scrolled;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [15:0] cell_value;
    } t_console_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;  // char_code[7:0], read_row[12:8], read_column[19:13]
    logic [0:0]  i_s_axis_tuser = '0;  // operation[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;       // cell_value[15:0], cursor_column[22:16],
                                       // cursor_row[27:23], scrolled[28]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_cursor_scroll_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // screen and cursor shadow
    logic [15:0] screen_shadow [tccs_pkg::CELLS];
    int          shadow_col = 0;
    int          shadow_row = 0;
    logic [3:0]  fg_shadow = 4'd15;
    logic [3:0]  bg_shadow = 4'd0;

    t_console_item console_items[$];
    t_console_word predicted_words[$];
    t_console_item offered;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned nl_pct = 5;
    logic        sink_hold_req = 1'b0;
    int unsigned sink_hold_left = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_puts = 0;
    int unsigned n_reads = 0;
    int unsigned n_outside = 0;
    int unsigned n_scrolls = 0;
    int unsigned n_words = 0;

    task automatic log_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
        mismatch_count++;
        $display("cycle %0d: %s expected 0x%0h got 0x%0h", cycle_count, what, want, got);
    endtask

    function automatic t_console_word console_step(input t_console_item it);
        t_console_word w;
        int col;
        int row;
        int idx;
        w = '0;
        col = shadow_col;
        row = shadow_row;
        if (it.op == tccs_pkg::OP_PUT) begin
            n_puts++;
            if (it.ch == tccs_pkg::CH_NL) begin
                col = 0;
                row++;
            end else if (it.ch == tccs_pkg::CH_CR) begin
                col = 0;
            end else if (it.ch == tccs_pkg::CH_TAB) begin
                col = (col + 4) & ~3;
            end else begin
                screen_shadow[row * tccs_pkg::COLUMNS + col] = {bg_shadow, fg_shadow, it.ch};
                col++;
            end
            if (col >= tccs_pkg::COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= tccs_pkg::ROWS) begin
                for (idx = 0; idx < tccs_pkg::CELLS - tccs_pkg::COLUMNS; idx++)
                    screen_shadow[idx] = screen_shadow[idx + tccs_pkg::COLUMNS];
                for (idx = tccs_pkg::CELLS - tccs_pkg::COLUMNS; idx < tccs_pkg::CELLS; idx++)
                    screen_shadow[idx] = tccs_pkg::BLANK_CELL;
                row = tccs_pkg::ROWS - 1;
                w.scrolled = 1'b1;
                n_scrolls++;
            end
            shadow_col = col;
            shadow_row = row;
        end else begin
            n_reads++;
            if (it.rrow < tccs_pkg::ROWS && it.rcol < tccs_pkg::COLUMNS)
                w.cell_value = screen_shadow[it.rrow * tccs_pkg::COLUMNS + it.rcol];
            else
                n_outside++;
        end
        w.cursor_col = shadow_col[6:0];
        w.cursor_row = shadow_row[4:0];
        return w;
    endfunction

    function automatic t_console_item random_item();
        t_console_item it;
        int unsigned pick;
        it.ch   = 8'($urandom);
        it.rrow = 5'($urandom);
        it.rcol = 7'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.op = tccs_pkg::OP_READ;
            // mostly on-screen reads, some anywhere the fields reach
            if ($urandom_range(9) < 8) begin
                it.rrow = 5'($urandom_range(tccs_pkg::ROWS - 1));
                it.rcol = 7'($urandom_range(tccs_pkg::COLUMNS - 1));
            end
        end else begin
            it.op = tccs_pkg::OP_PUT;
            pick = $urandom_range(99);
            if (pick < nl_pct)
                it.ch = tccs_pkg::CH_NL;
            else if (pick < nl_pct + 4)
                it.ch = tccs_pkg::CH_CR;
            else if (pick < nl_pct + 16)
                it.ch = tccs_pkg::CH_TAB;
        end
        return it;
    endfunction

    task automatic add_item(input logic op, input logic [7:0] ch,
                            input logic [4:0] rrow, input logic [6:0] rcol);
        console_items.push_back(t_console_item'{op: op, rcol: rcol, rrow: rrow, ch: ch});
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (console_items.size() != 0 || i_s_axis_tvalid || predicted_words.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apb_write(input logic regsel, input logic [3:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_FFF0) | value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (regsel == tccs_pkg::REG_FG)
            fg_shadow = value;
        else
            bg_shadow = value;
    endtask

    // input side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                predicted_words.push_back(console_step(offered));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (console_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered = console_items.pop_front();
                    i_s_axis_tdata  <= {4'b0, offered.rcol, offered.rrow, offered.ch};
                    i_s_axis_tuser  <= offered.op;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_left <= LONG_HOLD_CYCLES;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    // output side monitor and checker
    always @(posedge i_clk) begin
        t_console_word got;
        t_console_word want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_words++;
                got = o_m_axis_tdata[28:0];
                if (predicted_words.size() == 0) begin
                    log_mismatch("word with nothing pending", 0, o_m_axis_tdata);
                end else begin
                    want = predicted_words.pop_front();
                    if (got.cell_value != want.cell_value)
                        log_mismatch("cell_value", 32'(want.cell_value),
                                     32'(got.cell_value));
                    if (got.cursor_col != want.cursor_col)
                        log_mismatch("cursor_column", 32'(want.cursor_col),
                                     32'(got.cursor_col));
                    if (got.cursor_row != want.cursor_row)
                        log_mismatch("cursor_row", 32'(want.cursor_row),
                                     32'(got.cursor_row));
                    if (got.scrolled != want.scrolled)
                        log_mismatch("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                    if (o_m_axis_tdata[31:29] != 3'b000)
                        log_mismatch("tdata pad bits", 0, 32'(o_m_axis_tdata[31:29]));
                end
            end
            i_m_axis_tready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     predicted_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int phase;
        int k;
        for (k = 0; k < tccs_pkg::CELLS; k++)
            screen_shadow[k] = tccs_pkg::BLANK_CELL;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // blank screen at two corners and outside it
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_READ, 8'hFF, 5'd24, 7'd79);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd25, 7'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd80);
        add_item(tccs_pkg::OP_READ, 8'hFF, 5'd31, 7'd127);
        // plain bytes including zero and the high range, tab, return and newline, read back
        add_item(tccs_pkg::OP_PUT, 8'h41, 5'd31, 7'd127);
        add_item(tccs_pkg::OP_PUT, 8'h00, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, 8'h80, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::CH_TAB, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, 8'h7F, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::CH_TAB, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::CH_CR, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, 8'h42, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::CH_NL, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_PUT, 8'h43, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd1);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd3);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd4);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd0, 7'd8);
        add_item(tccs_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            // alternate newline-heavy and text-heavy phases for scrolls and wraps
            nl_pct = (phase % 2 != 0) ? 14 : 3;
            if (phase > 0) begin
                repeat (8) @(posedge i_clk);
                case (phase)
                    1: begin
                        apb_write(tccs_pkg::REG_FG, 4'd0);
                        apb_write(tccs_pkg::REG_BG, 4'd0);
                    end
                    2: begin
                        apb_write(tccs_pkg::REG_FG, 4'd15);
                        apb_write(tccs_pkg::REG_BG, 4'd15);
                    end
                    3: begin
                        apb_write(tccs_pkg::REG_FG, 4'd0);
                        apb_write(tccs_pkg::REG_BG, 4'd15);
                    end
                    4: begin
                        apb_write(tccs_pkg::REG_FG, 4'd15);
                        apb_write(tccs_pkg::REG_BG, 4'd0);
                    end
                    default: begin
                        apb_write(tccs_pkg::REG_FG, 4'($urandom));
                        apb_write(tccs_pkg::REG_BG, 4'($urandom));
                    end
                endcase
                @(negedge i_clk);
            end
            for (k = 0; k < ITEMS_PER_PHASE / 2; k++)
                console_items.push_back(random_item());
            // receiver goes quiet while the sender keeps offering
            if (phase == 4) begin
                sink_hold_req = 1'b1;
                @(negedge i_clk);
                sink_hold_req = 1'b0;
            end
            wait_drained();
            // sender pauses with everything delivered
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            for (k = 0; k < ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2; k++)
                console_items.push_back(random_item());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_words.size() != 0)
            log_mismatch("words never delivered", 0, predicted_words.size());
        $display("covered %0d puts with %0d scrolls and %0d reads (%0d off screen)",
                 n_puts, n_scrolls, n_reads, n_outside);
        $display("%0d words checked over %0d gap/stall/color phases, %0d mismatches",
                 n_words, PHASES, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
